// ===== rtl/tds_pkg.sv =====
package tds_pkg;

    localparam int MAX_TASKS  = 32;
    // Only 32 ids can be addressed, whatever MAX_TASKS says
    localparam int TASK_SLOTS = 32;
    localparam int SLOT_LIMIT = (MAX_TASKS < TASK_SLOTS) ? MAX_TASKS : TASK_SLOTS;

    localparam int IDX_W  = 5;
    localparam int NF_W   = 6;
    localparam int PCNT_W = 6;
    localparam logic [PCNT_W-1:0] PCNT_MAX = {PCNT_W{1'b1}};

    typedef logic [2:0]       t_cmd;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [1:0]       t_kind;

    localparam t_cmd CMD_CREATE  = 3'd0;
    localparam t_cmd CMD_ADD_DEP = 3'd1;
    localparam t_cmd CMD_RUN     = 3'd2;
    localparam t_cmd CMD_RUN_ALL = 3'd3;
    localparam t_cmd CMD_DONE    = 3'd4;
    localparam t_cmd CMD_QUERY   = 3'd5;

    localparam t_kind KIND_CREATED = 2'd0;
    localparam t_kind KIND_READY   = 2'd1;
    localparam t_kind KIND_ACK     = 2'd2;
    localparam t_kind KIND_REJECT  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

endpackage

// ===== rtl/tds_ram.sv =====
module tds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/task_dependency_scheduler.sv =====
// Task dependency scheduler. One command word is taken at a time; the input
// stalls until its last result word has been loaded into the output register.
// create, add_dependency, run and query answer from the execute state.
// run_all and complete sweep the created tasks one per cycle through the
// pending-count RAM port, unless a release must wait on a stalled output.
// Releases come out in rising id order; the final word of every command has
// last set. No clearing pass after reset: a task's RAM entries are written
// when it is created, and only the entries of created tasks are ever used.
module task_dependency_scheduler (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tds_pkg::t_cmd  i_command,
    input  tds_pkg::t_idx  i_task_index,
    input  logic           i_task_handle_ok,
    input  tds_pkg::t_idx  i_prereq_index,
    input  logic           i_prereq_handle_ok,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tds_pkg::t_kind o_kind,
    output tds_pkg::t_idx  o_result_index,
    output logic           o_is_done,
    output logic           o_last
);

    import tds_pkg::*;

    t_state r_state, n_state;
    logic [NF_W-1:0]       r_nf, n_nf;
    logic [TASK_SLOTS-1:0] r_done, n_done;
    logic                  r_out_valid, n_out_valid;
    logic                  r_held_valid, n_held_valid;

    // command word and scan payload
    t_cmd                  r_cmd;
    t_idx                  r_t, r_p;
    logic                  r_t_ok, r_p_ok;
    logic [TASK_SLOTS-1:0] r_mask, n_mask;
    t_idx                  r_i, n_i;
    t_idx                  r_held_idx, n_held_idx;
    t_kind                 r_kind;
    t_idx                  r_idx;
    logic                  r_is_done, r_last;

    // RAM ports
    logic                  pc_we, pc_re;
    t_idx                  pc_waddr, pc_raddr;
    logic [PCNT_W-1:0]     pc_wdata, pc_rdata;
    logic                  dm_we, dm_re;
    t_idx                  dm_waddr, dm_raddr;
    logic [TASK_SLOTS-1:0] dm_wdata, dm_rdata;

    logic                  accept, out_free;
    logic                  emit;
    t_kind                 e_kind;
    t_idx                  e_idx;
    logic                  e_done, e_last;
    logic                  t_exists, p_exists;
    logic                  found, dec, block, last_entry;

    tds_ram #(.WIDTH(PCNT_W), .DEPTH(TASK_SLOTS)) u_pending (
        .i_clk   (i_clk),
        .i_we    (pc_we),
        .i_waddr (pc_waddr),
        .i_wdata (pc_wdata),
        .i_re    (pc_re),
        .i_raddr (pc_raddr),
        .o_rdata (pc_rdata)
    );

    tds_ram #(.WIDTH(TASK_SLOTS), .DEPTH(TASK_SLOTS)) u_depmap (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (dm_raddr),
        .o_rdata (dm_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign t_exists   = ({1'b0, r_t} < r_nf);
    assign p_exists   = ({1'b0, r_p} < r_nf);
    assign last_entry = (({1'b0, r_i} + NF_W'(1)) == r_nf);

    always_comb begin
        n_state      = r_state;
        n_nf         = r_nf;
        n_done       = r_done;
        n_mask       = r_mask;
        n_i          = r_i;
        n_held_valid = r_held_valid;
        n_held_idx   = r_held_idx;
        emit         = 1'b0;
        e_kind       = KIND_ACK;
        e_idx        = '0;
        e_done       = 1'b0;
        e_last       = 1'b1;
        pc_we        = 1'b0;
        pc_waddr     = r_t;
        pc_wdata     = '0;
        pc_re        = 1'b0;
        pc_raddr     = i_task_index;
        dm_we        = 1'b0;
        dm_waddr     = r_p;
        dm_wdata     = '0;
        dm_re        = accept;
        dm_raddr     = (i_command == CMD_ADD_DEP) ? i_prereq_index : i_task_index;
        found        = 1'b0;
        dec          = 1'b0;
        block        = 1'b0;

        case (r_state)
            S_IDLE: begin
                pc_re = accept;
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_CREATE: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (r_nf >= NF_W'(SLOT_LIMIT)) begin
                                e_kind = KIND_REJECT;
                            end else begin
                                e_kind   = KIND_CREATED;
                                e_idx    = r_nf[IDX_W-1:0];
                                pc_we    = 1'b1;
                                pc_waddr = r_nf[IDX_W-1:0];
                                dm_we    = 1'b1;
                                dm_waddr = r_nf[IDX_W-1:0];
                                n_done[r_nf[IDX_W-1:0]] = 1'b0;
                                n_nf     = r_nf + NF_W'(1);
                            end
                        end
                    end
                    CMD_ADD_DEP: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (!r_t_ok || !r_p_ok || !t_exists || !p_exists) begin
                                e_kind = KIND_REJECT;
                            end else begin
                                e_kind = KIND_ACK;
                                // duplicate edge: leave the count alone
                                if (!dm_rdata[r_t]) begin
                                    dm_we          = 1'b1;
                                    dm_waddr       = r_p;
                                    dm_wdata       = dm_rdata;
                                    dm_wdata[r_t]  = 1'b1;
                                    pc_we          = 1'b1;
                                    pc_waddr       = r_t;
                                    pc_wdata       = (pc_rdata == PCNT_MAX) ? pc_rdata
                                                   : pc_rdata + PCNT_W'(1);
                                end
                            end
                        end
                    end
                    CMD_RUN: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (!r_t_ok || !t_exists) begin
                                e_kind = KIND_REJECT;
                            end else if (pc_rdata == '0 && !r_done[r_t]) begin
                                e_kind = KIND_READY;
                                e_idx  = r_t;
                            end else begin
                                e_kind = KIND_ACK;
                            end
                        end
                    end
                    CMD_QUERY: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (!r_t_ok || !t_exists) begin
                                e_kind = KIND_REJECT;
                            end else begin
                                e_kind = KIND_ACK;
                                e_done = r_done[r_t];
                            end
                        end
                    end
                    CMD_RUN_ALL, CMD_DONE: begin
                        if (r_cmd == CMD_DONE && (!r_t_ok || !t_exists || r_done[r_t])) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                e_kind  = KIND_REJECT;
                                n_state = S_IDLE;
                            end
                        end else begin
                            if (r_cmd == CMD_DONE) begin
                                n_done[r_t] = 1'b1;
                                n_mask      = dm_rdata;
                            end
                            n_held_valid = 1'b0;
                            n_i          = '0;
                            pc_re        = 1'b1;
                            pc_raddr     = '0;
                            n_state      = (r_nf == '0) ? S_FLUSH : S_SCAN;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            e_kind  = KIND_REJECT;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (r_cmd == CMD_RUN_ALL) begin
                    found = (pc_rdata == '0) && !r_done[r_i];
                end else begin
                    dec   = r_mask[r_i] && (pc_rdata != '0);
                    found = dec && (pc_rdata == PCNT_W'(1)) && !r_done[r_i];
                end
                // a release pushes the held word out; hold the entry if the output is busy
                block    = found && r_held_valid && !out_free;
                pc_re    = 1'b1;
                pc_raddr = block ? r_i : r_i + IDX_W'(1);
                if (!block) begin
                    pc_we    = dec;
                    pc_waddr = r_i;
                    pc_wdata = pc_rdata - PCNT_W'(1);
                    if (found) begin
                        if (r_held_valid) begin
                            emit   = 1'b1;
                            e_kind = KIND_READY;
                            e_idx  = r_held_idx;
                            e_last = 1'b0;
                        end
                        n_held_valid = 1'b1;
                        n_held_idx   = r_i;
                    end
                    n_i = r_i + IDX_W'(1);
                    if (last_entry) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    emit         = 1'b1;
                    e_kind       = r_held_valid ? KIND_READY : KIND_ACK;
                    e_idx        = r_held_valid ? r_held_idx : '0;
                    n_held_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = emit ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nf         <= '0;
            r_done       <= '0;
            r_out_valid  <= 1'b0;
            r_held_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nf         <= n_nf;
            r_done       <= n_done;
            r_out_valid  <= n_out_valid;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_t    <= i_task_index;
            r_t_ok <= i_task_handle_ok;
            r_p    <= i_prereq_index;
            r_p_ok <= i_prereq_handle_ok;
        end
        r_mask     <= n_mask;
        r_i        <= n_i;
        r_held_idx <= n_held_idx;
        if (emit) begin
            r_kind    <= e_kind;
            r_idx     <= e_idx;
            r_is_done <= e_done;
            r_last    <= e_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_result_index = r_idx;
    assign o_is_done      = r_is_done;
    assign o_last         = r_last;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_EXEC)
        else $error("accepted word did not enter execution");

    a_nf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= NF_W'(SLOT_LIMIT))
        else $error("task count beyond slot limit");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_nf != '0)
        else $error("scan running over an empty table");

    a_held_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("held release outside a sweep");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit)
        else $error("output word overwritten while stalled");

endmodule
